/* rtl/sha_pkg.sv */
// Shared types, constants and round functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps
package sha_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } back_state_t;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  function automatic logic [31:0] h_init(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] k_const(input logic [5:0] t);
    logic [31:0] r;
    case (t)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

/* rtl/sha_front.sv */
// Input front end: takes requests, drops empty ones and queues the rest.
`timescale 1ns / 1ps
module sha_front import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_valid,
  input  logic       in_end_of_message,
  output logic       q_valid,
  output req_t       q_req,
  input  logic       q_pop
);

  req_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           push;

  assign in_ready = (cnt_r != (QAW+1)'(QDEPTH));
  // Requests with no byte and no end mark change nothing: drop them
  assign push     = in_valid && in_ready && (in_byte_valid || in_end_of_message);
  assign q_valid  = (cnt_r != '0);
  assign q_req    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 1'b1;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // Store queued requests
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= '{data_byte: in_data_byte, byte_valid: in_byte_valid,
                                   end_of_message: in_end_of_message};
  end

endmodule

/* rtl/sha_back.sv */
// Hash engine: block fill, padding, 64-round compression and digest output.
`timescale 1ns / 1ps
module sha_back import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  req_t        q_req,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  back_state_t       state_r, state_nxt;
  logic [15:0][31:0] win_r;
  logic [31:0]       v_r [8];
  logic [31:0]       h_r [8];
  logic [63:0]       len_r;
  logic [5:0]        pos_r;
  logic [5:0]        rnd_r;
  logic [2:0]        idx_r;
  logic              eom_pend_r, pad_r, last_r;

  logic              put_en;
  logic [7:0]        put_byte;
  logic [63:0]       bits;
  logic [5:0]        len_sh;
  logic [31:0]       w_new, t1, t2;

  assign bits   = {len_r[60:0], 3'b000};
  assign len_sh = {3'd7 - pos_r[2:0], 3'b000};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_req.byte_valid && pos_r == 6'd63) state_nxt = ST_ROUND;
          else if (q_req.end_of_message) state_nxt = ST_PAD80;
        end
      end
      ST_PAD80, ST_PADZ: begin
        if (pos_r == 6'd63) state_nxt = ST_ROUND;
        else if (pos_r == LEN_START - 6'd1) state_nxt = ST_PADLEN;
        else state_nxt = ST_PADZ;
      end
      ST_PADLEN: if (pos_r == 6'd63) state_nxt = ST_ROUND;
      ST_ROUND:  if (rnd_r == 6'd63) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (last_r) state_nxt = ST_EMIT;
        else if (pad_r) state_nxt = ST_PADZ;
        else if (eom_pend_r) state_nxt = ST_PAD80;
        else state_nxt = ST_IDLE;
      end
      ST_EMIT:   if (out_ready && idx_r == 3'd7) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and byte insertion
  always_comb begin
    q_pop    = 1'b0;
    put_en   = 1'b0;
    put_byte = 8'h00;
    case (state_r)
      ST_IDLE: begin
        q_pop    = q_valid;
        put_en   = q_valid && q_req.byte_valid;
        put_byte = q_req.data_byte;
      end
      ST_PAD80: begin
        put_en   = 1'b1;
        put_byte = PAD_BYTE;
      end
      ST_PADZ:   put_en = 1'b1;
      ST_PADLEN: begin
        put_en   = 1'b1;
        put_byte = 8'(bits >> len_sh);
      end
      default: ;
    endcase
  end

  assign out_valid       = (state_r == ST_EMIT);
  assign out_digest_word = h_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  // Round datapath
  assign w_new = sig1(win_r[1]) + win_r[6] + sig0(win_r[14]) + win_r[15];
  assign t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + k_const(rnd_r) + win_r[15];
  assign t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      len_r      <= '0;
      pos_r      <= '0;
      rnd_r      <= '0;
      idx_r      <= '0;
      eom_pend_r <= 1'b0;
      pad_r      <= 1'b0;
      last_r     <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= h_init(3'(i));
    end else begin
      state_r <= state_nxt;
      if (put_en) pos_r <= pos_r + 1'b1;
      if (state_r == ST_IDLE && put_en) len_r <= len_r + 1'b1;
      if (state_r == ST_IDLE && q_valid && q_req.byte_valid && q_req.end_of_message
          && pos_r == 6'd63) eom_pend_r <= 1'b1;
      if (state_r == ST_PAD80) begin
        pad_r      <= 1'b1;
        eom_pend_r <= 1'b0;
      end
      if (state_r == ST_PADLEN && pos_r == 6'd63) last_r <= 1'b1;
      if (state_r == ST_ROUND) rnd_r <= rnd_r + 1'b1;
      if (state_r == ST_FOLD)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      // Hand out digest words; restart the message after the last one
      if (state_r == ST_EMIT && out_ready) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == 3'd7) begin
          len_r  <= '0;
          pad_r  <= 1'b0;
          last_r <= 1'b0;
          for (int i = 0; i < 8; i++) h_r[i] <= h_init(3'(i));
        end
      end
    end
  end

  // Block buffer doubles as the schedule window; working variables
  always_ff @(posedge clk) begin
    if (put_en) win_r <= {win_r[15][23:0], win_r[14:0], put_byte};
    else if (state_r == ST_ROUND) win_r <= {win_r[14:0], w_new};
    if (state_nxt == ST_ROUND && state_r != ST_ROUND) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (state_r == ST_ROUND) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

endmodule

/* rtl/sha256_stream_hasher_unit.sv */
// Top level of the SHA-256 stream hasher: request queue and hash engine.
// The engine takes a queued request whenever it is idle; requests queue four deep.
// A full 64-byte block is then compressed in 64 rounds followed by one fold.
// Padding inserts one byte per cycle, pausing while a full block is compressed;
// after the last block is folded, the digest is handed out as eight words.
// Synchronous active-low reset restores the initial hash and empties the queue.
`timescale 1ns / 1ps
module sha256_stream_hasher_unit import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic q_valid, q_pop;
  req_t q_req;

  sha_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_byte_valid,
    .in_end_of_message, .q_valid, .q_req, .q_pop
  );

  sha_back u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_pop, .out_valid, .out_ready,
    .out_digest_word, .out_word_index, .out_last_word
  );

endmodule

/* rtl/sha_checker.sv */
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
`timescale 1ns / 1ps
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last flag does not match word index");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word))
    else $error("stalled digest word changed");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
      out_valid && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest words out of sequence");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_word |=> !out_valid)
    else $error("new digest right after the last word");

endmodule

bind sha256_stream_hasher_unit sha_checker u_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last_word
);
